@@ hdl/opm_pkg.sv @@
package opm_pkg;

    // Converter resolution; only the low ADC_BITS bits of a sample are used.
    localparam int ADC_BITS = 16;
    localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 32'd1);

    // Conversion constants.
    localparam logic [15:0] RANGE_COUNTS = 16'd5000;
    localparam logic [19:0] SPAN_TENTHS  = 20'd200;
    localparam logic [19:0] MAX_TENTHS   = 20'd500;
    localparam logic [5:0]  BOLUS_LEVEL  = 6'd15;
    localparam logic [2:0]  PRE_SAMPLES  = 3'd5;
    localparam logic [1:0]  OVER_SAMPLES = 2'd3;

    // Serial divider length: one quotient bit per cycle.
    localparam int DIV_STEPS = 20;
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    // Configuration register indexes.
    localparam logic [2:0] REG_ZERO_COUNT      = 3'd0;
    localparam logic [2:0] REG_SPAN_COUNT      = 3'd1;
    localparam logic [2:0] REG_OCCLUSION_LEVEL = 3'd2;
    localparam logic [2:0] REG_BOLUS_MODE      = 3'd3;

    // Classification of a sample by the front end.
    localparam logic [1:0] KIND_HOLD = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic [15:0] zero_count;
        logic [15:0] span_count;
        logic [5:0]  occlusion_level;
        logic        bolus_mode;
    } opm_cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] dividend;
        logic        pump_running;
    } opm_item_t;

    typedef struct packed {
        logic [8:0] pressure_tenths;
        logic       pre_occlusion;
        logic       warning_cleared;
        logic       occlusion_detected;
    } opm_result_t;

endpackage

@@ hdl/opm_front.sv @@
module opm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  opm_pkg::opm_cfg_t cfg,
    input  logic [15:0]       adc_sample,
    input  logic              pump_running,
    input  logic              push,
    output logic              full,
    output logic              item_valid,
    output opm_pkg::opm_item_t item,
    input  logic              item_take
);

    logic [15:0]        sample;
    logic [15:0]        diff;
    logic               cal_valid;
    logic               in_range;
    opm_pkg::opm_item_t entry;
    opm_pkg::opm_item_t mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               do_push;
    logic               do_pop;

    // Classify the sample against the calibration.
    always_comb
    begin
        sample    = adc_sample & opm_pkg::ADC_MASK;
        diff      = sample - cfg.zero_count;
        cal_valid = (cfg.zero_count != 16'd0) && (cfg.span_count > cfg.zero_count);
        in_range  = (sample > cfg.zero_count) && (diff <= opm_pkg::RANGE_COUNTS);
        entry.pump_running = pump_running;
        entry.dividend     = {7'd0, diff[12:0]} * opm_pkg::SPAN_TENTHS;
        if (!cal_valid)
        begin
            entry.kind = opm_pkg::KIND_HOLD;
        end
        else if (in_range)
        begin
            entry.kind = opm_pkg::KIND_DIV;
        end
        else
        begin
            entry.kind = opm_pkg::KIND_ZERO;
        end
    end

    // Two-word queue toward the back end.
    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

endmodule

@@ hdl/opm_back.sv @@
module opm_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  opm_pkg::opm_cfg_t    cfg,
    input  logic                 item_valid,
    input  opm_pkg::opm_item_t   item,
    output logic                 item_take,
    input  logic                 res_space,
    output logic                 res_push,
    output opm_pkg::opm_result_t res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [1:0]  kind_reg;
    logic        running_reg;
    logic [19:0] dq_reg;
    logic [15:0] rem_reg;
    logic [4:0]  step_reg;
    logic [8:0]  pressure_reg;
    logic [2:0]  pre_count_reg;
    logic        pre_flag_reg;
    logic [1:0]  over_count_reg;

    logic [15:0] divisor;
    logic [16:0] rem_shift;
    logic        qbit;
    logic [8:0]  pressure_next;
    logic [2:0]  pre_count_next;
    logic        pre_flag_next;
    logic [1:0]  over_count_next;
    logic [1:0]  over_inc;
    logic [5:0]  level;
    logic [9:0]  pre_thr;
    logic [9:0]  full_thr;
    logic        cleared;
    logic        detected;

    assign item_take = (state_reg == ST_IDLE) && item_valid && res_space;
    assign res_push  = (state_reg == ST_UPD);

    // One restoring division step per cycle.
    always_comb
    begin
        divisor   = cfg.span_count - cfg.zero_count;
        rem_shift = {rem_reg, dq_reg[19]};
        qbit      = (rem_shift >= {1'b0, divisor});
    end

    // New pressure: the finished division, zero, or the held value, by the word's kind.
    always_comb
    begin
        case (kind_reg)
            opm_pkg::KIND_DIV:
            begin
                if (dq_reg > opm_pkg::MAX_TENTHS)
                begin
                    pressure_next = opm_pkg::MAX_TENTHS[8:0];
                end
                else
                begin
                    pressure_next = dq_reg[8:0];
                end
            end
            opm_pkg::KIND_ZERO: pressure_next = 9'd0;
            default:            pressure_next = pressure_reg;
        endcase
    end

    // Level checks on the new pressure.
    always_comb
    begin
        level = cfg.occlusion_level;
        if ((level != 6'd0) && (level <= opm_pkg::BOLUS_LEVEL) && cfg.bolus_mode)
        begin
            level = opm_pkg::BOLUS_LEVEL;
        end
        pre_thr  = 10'(({4'd0, level} * 10'd15) >> 1);
        full_thr = {4'd0, level} * 10'd10;
        over_inc = over_count_reg + 2'd1;

        pre_count_next  = pre_count_reg;
        pre_flag_next   = pre_flag_reg;
        over_count_next = over_count_reg;
        cleared         = 1'b0;
        detected        = 1'b0;

        if (level != 6'd0)
        begin
            if ({1'b0, pressure_next} >= pre_thr)
            begin
                if (pre_count_reg >= opm_pkg::PRE_SAMPLES)
                begin
                    pre_flag_next = 1'b1;
                end
                else
                begin
                    pre_count_next = pre_count_reg + 3'd1;
                end
            end
            else if ((pre_count_reg != 3'd0) || pre_flag_reg)
            begin
                pre_count_next = 3'd0;
                pre_flag_next  = 1'b0;
                cleared        = 1'b1;
            end

            if ({1'b0, pressure_next} >= full_thr)
            begin
                over_count_next = over_inc;
            end
            else
            begin
                over_count_next = 2'd0;
            end

            if (over_count_next >= opm_pkg::OVER_SAMPLES)
            begin
                over_count_next = 2'd0;
                detected        = running_reg || cfg.bolus_mode;
            end
        end

        res.pressure_tenths    = pressure_next;
        res.pre_occlusion      = pre_flag_next;
        res.warning_cleared    = cleared;
        res.occlusion_detected = detected;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    state_next = (item.kind == opm_pkg::KIND_DIV) ? ST_DIV : ST_UPD;
                end
            end
            ST_DIV:
            begin
                if (step_reg == opm_pkg::DIV_LAST)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pressure_reg   <= 9'd0;
            pre_count_reg  <= 3'd0;
            pre_flag_reg   <= 1'b0;
            over_count_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPD)
            begin
                pressure_reg   <= pressure_next;
                pre_count_reg  <= pre_count_next;
                pre_flag_reg   <= pre_flag_next;
                over_count_reg <= over_count_next;
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            kind_reg    <= item.kind;
            running_reg <= item.pump_running;
            dq_reg      <= item.dividend;
            rem_reg     <= 16'd0;
            step_reg    <= 5'd0;
        end
        else if (state_reg == ST_DIV)
        begin
            dq_reg   <= {dq_reg[18:0], qbit};
            rem_reg  <= qbit ? 16'(rem_shift - {1'b0, divisor}) : rem_shift[15:0];
            step_reg <= step_reg + 5'd1;
        end
    end

endmodule

@@ hdl/opm_result_q.sv @@
module opm_result_q
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    input  opm_pkg::opm_result_t res,
    output logic                 res_space,
    output opm_pkg::opm_result_t head,
    output logic                 empty,
    input  logic                 pop
);

    opm_pkg::opm_result_t mem [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 do_push;
    logic                 do_pop;

    assign res_space = (count_reg != 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = res_push && res_space;
    assign do_pop    = pop && !empty;

    // Occupancy update.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= res;
        end
    end

endmodule

@@ hdl/occlusion_pressure_monitor.sv @@
// A word pushed into an idle block goes through the 20-step serial divider in the back end
// when it needs it and straight to the update when the calibration holds or zeroes it.
// The back end takes no new word until it has pushed the result of the last one.
// Two-word queues on both sides absorb stalls of either neighbor.
// Reset (rst_n low, asynchronous) clears the configuration, the pressure and the
// warning counters and empties both queues; no clearing pass is needed.
module occlusion_pressure_monitor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] adc_sample,
    input  logic        pump_running,
    output logic        empty,
    input  logic        pop,
    output logic [8:0]  pressure_tenths,
    output logic        pre_occlusion,
    output logic        warning_cleared,
    output logic        occlusion_detected,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    opm_pkg::opm_cfg_t    cfg_reg;
    opm_pkg::opm_item_t   item;
    opm_pkg::opm_result_t res;
    opm_pkg::opm_result_t head;
    logic                 item_valid;
    logic                 item_take;
    logic                 res_space;
    logic                 res_push;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                opm_pkg::REG_ZERO_COUNT:      cfg_reg.zero_count      <= cfg_data;
                opm_pkg::REG_SPAN_COUNT:      cfg_reg.span_count      <= cfg_data;
                opm_pkg::REG_OCCLUSION_LEVEL: cfg_reg.occlusion_level <= cfg_data[5:0];
                opm_pkg::REG_BOLUS_MODE:      cfg_reg.bolus_mode      <= cfg_data[0];
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    opm_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .adc_sample   (adc_sample),
        .pump_running (pump_running),
        .push         (push),
        .full         (full),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    opm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_space  (res_space),
        .res_push   (res_push),
        .res        (res)
    );

    opm_result_q u_result_q
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .res       (res),
        .res_space (res_space),
        .head      (head),
        .empty     (empty),
        .pop       (pop)
    );

    // Result word fields.
    assign pressure_tenths    = head.pressure_tenths;
    assign pre_occlusion      = head.pre_occlusion;
    assign warning_cleared    = head.warning_cleared;
    assign occlusion_detected = head.occlusion_detected;

endmodule

@@ test/testbench.sv @@
module testbench;

    // Run limit in clock cycles; the slowest legal run stays well below it.
    localparam int unsigned CYCLE_LIMIT = 800000;
    // Number of index values the configuration port can carry.
    localparam int REG_SLOTS = 2 ** 3;
    // Cycles allowed after the last word before the block counts as idle.
    localparam int SETTLE_CYCLES = 30;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] adc_sample = '0;
    logic        pump_running = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [8:0]  pressure_tenths;
    logic        pre_occlusion;
    logic        warning_cleared;
    logic        occlusion_detected;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    occlusion_pressure_monitor dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .adc_sample(adc_sample),
        .pump_running(pump_running),
        .empty(empty),
        .pop(pop),
        .pressure_tenths(pressure_tenths),
        .pre_occlusion(pre_occlusion),
        .warning_cleared(warning_cleared),
        .occlusion_detected(occlusion_detected),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Calibration and alarm settings as the block should hold them.
    opm_pkg::opm_cfg_t cal = '0;

    // Monitor state as the block should hold it.
    logic [8:0] line_pressure = '0;
    logic [2:0] warn_count = '0;
    logic       warn_flag = 1'b0;
    logic [1:0] over_run = '0;

    // Expected result words, oldest first.
    opm_pkg::opm_result_t pending_results[$];

    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit          no_idle = 1'b0;

    // Sample generator state: a target pressure held over a run of words.
    int unsigned target = 0;
    int unsigned run_left = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stop the run if it takes far longer than any correct block needs.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("occlusion_pressure_monitor regression: fail");
        $finish;
    end

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Level actually used for detection, with the bolus raise applied.
    function automatic int unsigned alarm_level();
        int unsigned lvl;
        lvl = cal.occlusion_level;
        if (lvl >= 1 && lvl <= opm_pkg::BOLUS_LEVEL && cal.bolus_mode)
            lvl = opm_pkg::BOLUS_LEVEL;
        return lvl;
    endfunction

    function automatic void apply_config(logic [2:0] idx, logic [15:0] data);
        case (idx)
            opm_pkg::REG_ZERO_COUNT:      cal.zero_count = data;
            opm_pkg::REG_SPAN_COUNT:      cal.span_count = data;
            opm_pkg::REG_OCCLUSION_LEVEL: cal.occlusion_level = data[5:0];
            opm_pkg::REG_BOLUS_MODE:      cal.bolus_mode = data[0];
            default:                      ;
        endcase
    endfunction

    // Pressure conversion and warning logic for one accepted sample word.
    function automatic opm_pkg::opm_result_t predict_word(logic [15:0] raw, logic running);
        int unsigned s;
        int unsigned diff;
        int unsigned p;
        int unsigned lvl;
        opm_pkg::opm_result_t r;
        s = raw & opm_pkg::ADC_MASK;
        r = '0;
        if (cal.zero_count != 0 && cal.span_count > cal.zero_count)
        begin
            if (s > cal.zero_count && (s - cal.zero_count) <= opm_pkg::RANGE_COUNTS)
            begin
                diff = s - cal.zero_count;
                p = (diff * opm_pkg::SPAN_TENTHS) / (cal.span_count - cal.zero_count);
                if (p > opm_pkg::MAX_TENTHS)
                    p = opm_pkg::MAX_TENTHS;
            end
            else
                p = 0;
            line_pressure = p[8:0];
        end
        lvl = alarm_level();
        if (lvl != 0)
        begin
            // Pre-occlusion warning at three quarters of the level.
            if (line_pressure >= (lvl * 15) / 2)
            begin
                if (warn_count >= opm_pkg::PRE_SAMPLES)
                    warn_flag = 1'b1;
                else
                    warn_count++;
            end
            else if (warn_count != 0 || warn_flag)
            begin
                warn_count = '0;
                warn_flag = 1'b0;
                r.warning_cleared = 1'b1;
            end
            // Consecutive samples at or over the full level.
            if (line_pressure >= lvl * 10)
                over_run++;
            else
                over_run = '0;
            if (over_run >= opm_pkg::OVER_SAMPLES)
            begin
                over_run = '0;
                if (running || cal.bolus_mode)
                    r.occlusion_detected = 1'b1;
            end
        end
        r.pressure_tenths = line_pressure;
        r.pre_occlusion = warn_flag;
        return r;
    endfunction

    // Offer one sample word and wait until the block takes it.
    task automatic send_word(logic [15:0] sample, logic running);
        int unsigned gap;
        push <= 1'b1;
        adc_sample <= sample;
        pump_running <= running;
        do
            @(posedge clk);
        while (full);
        pending_results.push_back(predict_word(sample, running));
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_config(idx, data);
    endtask

    // Write all four registers while the block is idle.
    task automatic configure(int unsigned zero, int unsigned span, int unsigned lvl, bit bolus);
        wait_idle();
        write_reg(opm_pkg::REG_ZERO_COUNT, 16'(zero));
        write_reg(opm_pkg::REG_SPAN_COUNT, 16'(span));
        write_reg(opm_pkg::REG_OCCLUSION_LEVEL, 16'(lvl));
        write_reg(opm_pkg::REG_BOLUS_MODE, 16'(bolus));
        cfg_valid <= 1'b0;
    endtask

    // Random sample, often held near the thresholds of the current level, else at the range edge, near zero or random.
    function automatic logic [15:0] next_sample();
        int unsigned r;
        int unsigned dspan;
        int unsigned diff;
        int unsigned lvl;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'($urandom);
        dspan = (cal.span_count > cal.zero_count) ? cal.span_count - cal.zero_count : 1;
        if (r < 22)
            diff = opm_pkg::RANGE_COUNTS - 3 + $urandom_range(0, 6);
        else
        begin
            if (run_left == 0)
            begin
                lvl = alarm_level();
                case ($urandom_range(0, 3))
                    0:       target = lvl * 10;
                    1:       target = (lvl * 15) / 2;
                    2:       target = $urandom_range(0, 520);
                    default: target = 0;
                endcase
                target = (target >= 2) ? target - 2 : 0;
                target += $urandom_range(0, 4);
                run_left = $urandom_range(1, 8);
            end
            run_left--;
            diff = (target * dspan + 199) / 200 + $urandom_range(0, 1);
        end
        if (diff > 65535 - cal.zero_count)
            return 16'hFFFF;
        return 16'(cal.zero_count + diff);
    endfunction

    task automatic send_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_word(next_sample(), 1'($urandom));
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial
    begin : pop_driver
        int unsigned wait_left;
        int unsigned g;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (wait_left != 0)
            begin
                pop <= 1'b0;
                wait_left--;
            end
            else
            begin
                g = no_idle ? 0 : pick_gap();
                pop <= (g == 0);
                if (g != 0)
                    wait_left = g - 1;
            end
        end
    end

    // Compare each word taken from the block with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        opm_pkg::opm_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result word", pressure_tenths, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (pressure_tenths !== want.pressure_tenths)
                    report_mismatch("pressure_tenths", pressure_tenths, want.pressure_tenths);
                if (pre_occlusion !== want.pre_occlusion)
                    report_mismatch("pre_occlusion", pre_occlusion, want.pre_occlusion);
                if (warning_cleared !== want.warning_cleared)
                    report_mismatch("warning_cleared", warning_cleared, want.warning_cleared);
                if (occlusion_detected !== want.occlusion_detected)
                    report_mismatch("occlusion_detected", occlusion_detected,
                                    want.occlusion_detected);
            end
        end
    end

    // With the reset calibration the pressure stays at zero.
    task automatic test_uncalibrated();
        send_word(16'd0, 1'b0);
        send_word(16'hFFFF, 1'b1);
    endtask

    // Conversion limits: at or below zero, the range edge and the clamp.
    task automatic test_conversion_edges();
        configure(1000, 2000, 0, 1'b0);
        send_word(16'd0, 1'b1);
        send_word(16'd1000, 1'b0);
        send_word(16'd1001, 1'b1);
        send_word(16'd3500, 1'b0);
        send_word(16'd6000, 1'b1);
        send_word(16'd6001, 1'b0);
    endtask

    // A span at or below zero keeps the last pressure; unused indexes do nothing.
    task automatic test_calibration_hold();
        send_word(16'd2000, 1'b0);
        wait_idle();
        for (int i = int'(opm_pkg::REG_BOLUS_MODE) + 1; i < REG_SLOTS; i++)
            write_reg(3'(i), 16'($urandom));
        write_reg(opm_pkg::REG_SPAN_COUNT, 16'd1000);
        cfg_valid <= 1'b0;
        send_word(16'd3000, 1'b1);
        send_word(16'd50000, 1'b0);
    endtask

    // Pressure equals sample minus 100 here, so levels are easy to hit.
    task automatic test_warning_and_alarm();
        configure(100, 300, 10, 1'b0);
        repeat (6) send_word(16'd200, 1'b1);
        send_word(16'd150, 1'b1);
        repeat (3) send_word(16'd200, 1'b0);
    endtask

    // Bolus mode raises a low level and raises the alarm with the pump stopped.
    task automatic test_bolus_alarm();
        configure(100, 300, 5, 1'b1);
        repeat (3) send_word(16'd250, 1'b0);
    endtask

    // Phases of settings, extremes first, each with a run of random samples.
    task automatic test_register_sweep();
        int unsigned z;
        int unsigned s;
        int unsigned d;
        int unsigned lvl;
        bit bolus;
        for (int ph = 0; ph < 12; ph++)
        begin
            z = $urandom_range(1, 60000);
            case ($urandom_range(0, 2))
                0:       d = $urandom_range(1, 10);
                1:       d = $urandom_range(11, 500);
                default: d = $urandom_range(501, 20000);
            endcase
            s = (z + d > 65535) ? 65535 : z + d;
            if ($urandom_range(0, 5) == 0)
                s = $urandom_range(0, 65535);
            lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 50);
            bolus = 1'($urandom);
            case (ph)
                0:
                begin
                    z = 65535;
                    s = 65535;
                    lvl = 50;
                    bolus = 1'b1;
                end
                1:
                begin
                    z = 1;
                    s = 65535;
                    lvl = 1;
                    bolus = 1'b0;
                end
                2:
                begin
                    z = 0;
                    lvl = 63;
                end
                3:
                begin
                    s = (z < 65535) ? z + 1 : z;
                    lvl = 0;
                end
                default: ;
            endcase
            configure(z, s, lvl, bolus);
            send_random(65);
        end
    endtask

    // Both sides run without gaps.
    task automatic test_back_to_back();
        configure(500, 700, 12, 1'b0);
        no_idle = 1'b1;
        send_random(60);
        no_idle = 1'b0;
    endtask

    // The result side holds off long enough for the block to fill and stall.
    task automatic test_output_backpressure();
        configure(100, 300, 8, 1'b1);
        no_idle = 1'b1;
        hold_left = 400;
        send_random(12);
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_uncalibrated();
        test_conversion_edges();
        test_calibration_hold();
        test_warning_and_alarm();
        test_bolus_alarm();
        test_register_sweep();
        test_back_to_back();
        test_output_backpressure();
        wait_idle();
        if (mismatches == 0)
            $display("occlusion_pressure_monitor regression: pass");
        else
            $display("occlusion_pressure_monitor regression: fail");
        $finish;
    end

endmodule

@@ occlusion_pressure_monitor.f @@
hdl/opm_pkg.sv
hdl/opm_front.sv
hdl/opm_back.sv
hdl/opm_result_q.sv
hdl/occlusion_pressure_monitor.sv
test/testbench.sv
